[rtl/core/bgl_pkg.sv]
// package for the button gesture led counter
// register codes, mode and gesture codes, configuration and result types
// no dependencies
package bgl_pkg;

    localparam int CFG_W     = 16;
    localparam int TIMER_W   = 16;
    localparam int INDEX_W   = 3;
    localparam int LED_W     = 3;
    localparam int CODE_W    = 3;

    localparam logic [CFG_W-1:0] LONG_RELEASE_RST   = 16'd750;
    localparam logic [CFG_W-1:0] DOUBLE_GAP_RST     = 16'd150;
    localparam logic [CFG_W-1:0] LONG_START_RST     = 16'd200;
    localparam logic [CFG_W-1:0] SINGLE_CONFIRM_RST = 16'd150;
    localparam logic [CFG_W-1:0] POLL_PERIOD_RST    = 16'd80;

    localparam logic [LED_W-1:0] LED_ANIM_START = 3'd4;
    localparam logic [LED_W-1:0] LED_DEC_STEP   = 3'd7;

    typedef enum logic [INDEX_W-1:0] {
        REG_LONG_RELEASE   = 3'd0,
        REG_DOUBLE_GAP     = 3'd1,
        REG_LONG_START     = 3'd2,
        REG_SINGLE_CONFIRM = 3'd3,
        REG_POLL_PERIOD    = 3'd4
    } reg_index_t;

    typedef enum logic [CODE_W-1:0] {
        MODE_IDLE    = 3'd0,
        MODE_FIRST   = 3'd1,
        MODE_SECOND  = 3'd2,
        MODE_ANIM    = 3'd3,
        MODE_CONFIRM = 3'd4
    } mode_t;

    typedef enum logic [CODE_W-1:0] {
        GEST_NONE         = 3'd0,
        GEST_SINGLE       = 3'd1,
        GEST_DOUBLE       = 3'd2,
        GEST_LONG_RELEASE = 3'd3,
        GEST_LONG_START   = 3'd4
    } gesture_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_release;
        logic [CFG_W-1:0] double_gap;
        logic [CFG_W-1:0] long_start;
        logic [CFG_W-1:0] single_confirm;
        logic [CFG_W-1:0] poll_period;
    } cfg_t;

    typedef struct packed {
        logic [LED_W-1:0] led_count;
        gesture_t         gesture;
        mode_t            mode;
    } result_t;

endpackage

[rtl/core/bgl_cfg_regs.sv]
// configuration register file for the button gesture led counter
// depends on bgl_pkg
module bgl_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [bgl_pkg::INDEX_W-1:0]    wr_index,
    input  logic [bgl_pkg::CFG_W-1:0]      wr_data,
    output bgl_pkg::cfg_t                  cfg
);

    bgl_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_release   <= bgl_pkg::LONG_RELEASE_RST;
            cfg_reg.double_gap     <= bgl_pkg::DOUBLE_GAP_RST;
            cfg_reg.long_start     <= bgl_pkg::LONG_START_RST;
            cfg_reg.single_confirm <= bgl_pkg::SINGLE_CONFIRM_RST;
            cfg_reg.poll_period    <= bgl_pkg::POLL_PERIOD_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                bgl_pkg::REG_LONG_RELEASE:   cfg_reg.long_release   <= wr_data;
                bgl_pkg::REG_DOUBLE_GAP:     cfg_reg.double_gap     <= wr_data;
                bgl_pkg::REG_LONG_START:     cfg_reg.long_start     <= wr_data;
                bgl_pkg::REG_SINGLE_CONFIRM: cfg_reg.single_confirm <= wr_data;
                bgl_pkg::REG_POLL_PERIOD:    cfg_reg.poll_period    <= wr_data;
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/bgl_core.sv]
// gesture state and per-tick step logic for the button gesture led counter
// depends on bgl_pkg
module bgl_core
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             level,
    input  bgl_pkg::cfg_t    cfg,
    output bgl_pkg::result_t result
);

    localparam int CMP_W = (COUNTER_BITS > bgl_pkg::CFG_W) ? COUNTER_BITS : bgl_pkg::CFG_W;

    logic                             last_level_reg, last_level_next;
    logic                             second_press_reg, second_press_next;
    logic [COUNTER_BITS-1:0]          since_release_reg, since_release_next;
    logic [COUNTER_BITS-1:0]          since_press_reg, since_press_next;
    bgl_pkg::mode_t                   mode_reg, mode_next;
    logic [bgl_pkg::LED_W-1:0]        led_reg, led_next;
    logic [bgl_pkg::TIMER_W-1:0]      poll_timer_reg, poll_timer_next;

    logic [COUNTER_BITS-1:0]          sr_inc, sp_inc;
    logic [CMP_W-1:0]                 sr_wide, sp_wide;
    logic [bgl_pkg::TIMER_W-1:0]      timer_inc, period;
    bgl_pkg::mode_t                   mode_mid;
    logic [bgl_pkg::LED_W-1:0]        led_mid;
    bgl_pkg::gesture_t                gesture_mid, gesture_next;
    logic                             poll;

    always_comb
    begin
        sr_inc = (since_release_reg == '1) ? since_release_reg : since_release_reg + 1'b1;
        sp_inc = (since_press_reg == '1) ? since_press_reg : since_press_reg + 1'b1;

        since_release_next = sr_inc;
        since_press_next   = sp_inc;
        sr_wide            = CMP_W'(sr_inc);
        sp_wide            = CMP_W'(sp_inc);
        last_level_next    = level;
        second_press_next  = second_press_reg;
        mode_mid           = mode_reg;
        led_mid            = led_reg;
        gesture_mid        = bgl_pkg::GEST_NONE;

        // edge handling
        if (level != last_level_reg)
        begin
            if (level)
            begin
                if (sp_wide > CMP_W'(cfg.long_release))
                begin
                    mode_mid    = bgl_pkg::MODE_IDLE;
                    led_mid     = '0;
                    gesture_mid = bgl_pkg::GEST_LONG_RELEASE;
                end
                else if (second_press_reg)
                begin
                    mode_mid    = bgl_pkg::MODE_IDLE;
                    led_mid     = led_reg + bgl_pkg::LED_DEC_STEP;
                    gesture_mid = bgl_pkg::GEST_DOUBLE;
                end
                else
                begin
                    mode_mid = bgl_pkg::MODE_CONFIRM;
                end
                second_press_next  = 1'b0;
                since_release_next = '0;
            end
            else
            begin
                if (sr_wide < CMP_W'(cfg.double_gap))
                begin
                    second_press_next = 1'b1;
                    mode_mid          = bgl_pkg::MODE_SECOND;
                end
                else
                begin
                    mode_mid = bgl_pkg::MODE_FIRST;
                end
                since_press_next = '0;
            end
        end

        // poll, zero period runs every tick
        period          = (cfg.poll_period == '0) ? bgl_pkg::TIMER_W'(1) : cfg.poll_period;
        timer_inc       = poll_timer_reg + 1'b1;
        poll            = (timer_inc >= period);
        poll_timer_next = poll ? '0 : timer_inc;

        mode_next    = mode_mid;
        led_next     = led_mid;
        gesture_next = gesture_mid;

        if (poll)
        begin
            case (mode_mid) inside
                bgl_pkg::MODE_FIRST, bgl_pkg::MODE_SECOND:
                begin
                    if (CMP_W'(since_press_next) > CMP_W'(cfg.long_start))
                    begin
                        mode_next    = bgl_pkg::MODE_ANIM;
                        led_next     = bgl_pkg::LED_ANIM_START;
                        gesture_next = bgl_pkg::GEST_LONG_START;
                    end
                end
                bgl_pkg::MODE_ANIM:
                begin
                    led_next = (led_mid >> 1) == '0 ? bgl_pkg::LED_ANIM_START : (led_mid >> 1);
                end
                bgl_pkg::MODE_CONFIRM:
                begin
                    if (CMP_W'(since_release_next) > CMP_W'(cfg.single_confirm))
                    begin
                        mode_next    = bgl_pkg::MODE_IDLE;
                        led_next     = led_mid + 1'b1;
                        gesture_next = bgl_pkg::GEST_SINGLE;
                    end
                end
                default:
                begin
                    mode_next = mode_mid;
                end
            endcase
        end

        result.led_count = led_next;
        result.gesture   = gesture_next;
        result.mode      = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg    <= 1'b1;
            second_press_reg  <= 1'b0;
            since_release_reg <= '1;
            since_press_reg   <= '1;
            mode_reg          <= bgl_pkg::MODE_IDLE;
            led_reg           <= '0;
            poll_timer_reg    <= '0;
        end
        else if (step)
        begin
            last_level_reg    <= last_level_next;
            second_press_reg  <= second_press_next;
            since_release_reg <= since_release_next;
            since_press_reg   <= since_press_next;
            mode_reg          <= mode_next;
            led_reg           <= led_next;
            poll_timer_reg    <= poll_timer_next;
        end
    end

endmodule

[rtl/core/button_gesture_led_counter.sv]
// top level of the button gesture led counter
// depends on bgl_pkg, bgl_cfg_regs and bgl_core
//
// usage
//   one input item per millisecond tick carries button_level (1 released,
//   0 pressed) on the in_valid/in_ready channel; each item gives exactly one
//   result item (led_count, gesture, mode) on the out_valid/out_ready channel
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, register
//   indices 0 to 4, other indices ignored; cfg_ready is always high; the
//   user makes writes while no item is in flight, not enforced by the block
//   path: an accepted item passes the input register, then the result
//   register behind the step logic, and is then offered on the outputs
//   throughput: one item per cycle while out_ready is high, set by the step
//   logic, which updates the gesture state between the two registers
//   reset: state registers return to their defaults, button taken as released,
//   elapsed counters saturated, led count and poll timer zero, no items held
//   stall: while out_ready is low the result is held and the input register
//   keeps one more item; in_ready drops only when both are full
module button_gesture_led_counter
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           button_level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bgl_pkg::LED_W-1:0]      led_count,
    output logic [bgl_pkg::CODE_W-1:0]     gesture,
    output logic [bgl_pkg::CODE_W-1:0]     mode,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bgl_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [bgl_pkg::CFG_W-1:0]      cfg_data
);

    logic             in_valid_reg;
    logic             level_reg;
    logic             out_valid_reg;
    bgl_pkg::result_t result_reg;
    bgl_pkg::result_t step_result;
    bgl_pkg::cfg_t    cfg;
    logic             out_free;
    logic             advance;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;

    bgl_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bgl_core #(.COUNTER_BITS(COUNTER_BITS)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .level  (level_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            level_reg <= button_level;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_count = result_reg.led_count;
    assign gesture   = result_reg.gesture;
    assign mode      = result_reg.mode;

`ifndef NO_ASSERTIONS
    a_long_start_anim: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_reg.gesture == bgl_pkg::GEST_LONG_START)
        |-> (result_reg.mode == bgl_pkg::MODE_ANIM
             && result_reg.led_count == bgl_pkg::LED_ANIM_START))
        else $error("long start result without animation start");

    a_gesture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_reg.gesture == bgl_pkg::GEST_SINGLE
                       || result_reg.gesture == bgl_pkg::GEST_DOUBLE
                       || result_reg.gesture == bgl_pkg::GEST_LONG_RELEASE))
        |-> (result_reg.mode == bgl_pkg::MODE_IDLE))
        else $error("completed gesture did not return to idle");

    a_anim_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_reg.mode == bgl_pkg::MODE_ANIM)
        |-> $onehot(result_reg.led_count))
        else $error("animation pattern is not one-hot");

    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_free) |=> out_valid_reg)
        else $error("item in input register did not reach result register");
`endif

endmodule
